// ----- src/ptst_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer slot table package
// Words, operation codes, controller states and the command and status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package ptst_pkg;

    typedef logic [2:0] t_op;

    localparam t_op OP_REGISTER   = 3'd0;
    localparam t_op OP_UNREGISTER = 3'd1;
    localparam t_op OP_RESERVE    = 3'd2;
    localparam t_op OP_RUN_ONCE   = 3'd3;
    localparam t_op OP_SCAN       = 3'd4;

    // Most slots that one scan may fire.
    localparam int MAX_FIRES = 16;
    localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd10;

    typedef struct packed {
        t_op         operation;
        logic [3:0]  slot_id;
        logic [31:0] period_ms;
        logic [15:0] loop_count;
        logic        repeat_forever;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic       status;
        logic [3:0] result_id;
        logic       fired;
        logic       slot_freed;
        logic       last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_SCAN_END
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic single;
        logic search_step;
        logic scan_eval;
        logic scan_finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_search;
        logic is_scan;
        logic free_hit;
        logic idx_last;
        logic fires_full;
    } t_dp_stat;

endpackage

// ----- src/ptst_ctrl.sv -----
// ----------------------------------------------------------------------------
// Timer slot table controller
// Sequences operations finished in the accepting cycle, the free-slot search and the slot scan.
// ----------------------------------------------------------------------------
module ptst_ctrl
    import ptst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_stat.need_search) begin
                        n_state = ST_SEARCH;
                    end else if (i_stat.is_scan) begin
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_SEARCH: begin
                if (i_stat.free_hit || i_stat.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_EVAL;
            end
            ST_SCAN_EVAL: begin
                if (i_stat.idx_last || i_stat.fires_full) begin
                    n_state = ST_SCAN_END;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
                o_cmd.single = i_start && !i_stat.need_search && !i_stat.is_scan;
            end
            ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
            end
            ST_SCAN_RD: begin
            end
            ST_SCAN_EVAL: begin
                o_cmd.scan_eval = 1'b1;
            end
            ST_SCAN_END: begin
                o_cmd.scan_finish = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/ptst_dp.sv -----
// ----------------------------------------------------------------------------
// Timer slot table datapath
// Slot flag registers, period/base/loop memories, slot index, fire counter,
// pending scan result and the result register.
// ----------------------------------------------------------------------------
module ptst_dp
    import ptst_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int IDX_W     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_word    i_word,
    input  logic [15:0] i_min_interval,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_valid,
    output t_out_word   o_word
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [8:0]       NSLOT_9  = 9'(NUM_SLOTS);

    // Flag registers, cleared by reset.
    logic [NUM_SLOTS-1:0] r_used, n_used;
    logic [NUM_SLOTS-1:0] r_armed, n_armed;
    logic [NUM_SLOTS-1:0] r_forever, n_forever;

    // Per-slot memories, undefined until written.
    logic [31:0] r_period_mem [NUM_SLOTS];
    logic [31:0] r_base_mem   [NUM_SLOTS];
    logic [15:0] r_loops_mem  [NUM_SLOTS];
    logic [31:0] r_rd_period;
    logic [31:0] r_rd_base;
    logic [15:0] r_rd_loops;

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [FIRE_W-1:0] r_fires, n_fires;
    t_in_word          r_item;
    t_out_word         r_pend, n_pend;
    logic              r_pend_valid, n_pend_valid;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    // Memory write port.
    logic             we_period, we_base, we_loops;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wd_period, wd_base;
    logic [15:0]      wd_loops;

    // Index helpers.
    logic [IDX_W+3:0] idx_wide;
    logic [IDX_W+3:0] id_wide;
    logic [IDX_W-1:0] id_idx;
    logic [3:0]       rid;
    logic             id_ok;

    logic        period_ok_in, period_ok_item;
    logic        reg_ok, unreg_ok;
    logic        free_now, armed_now, fire;
    logic [31:0] elapsed;
    logic [15:0] loops_dec;
    logic        freed;
    t_out_word   fire_word;

    assign idx_wide = {4'b0000, r_idx};
    assign rid      = idx_wide[3:0];
    assign id_wide  = {{IDX_W{1'b0}}, i_word.slot_id};
    assign id_idx   = id_wide[IDX_W-1:0];
    assign id_ok    = ({5'b00000, i_word.slot_id} < NSLOT_9);

    assign period_ok_in   = (i_word.period_ms >= {16'h0000, i_min_interval});
    assign period_ok_item = (r_item.period_ms >= {16'h0000, i_min_interval});

    assign reg_ok = id_ok && period_ok_in
                 && ((i_word.loop_count != 16'h0000) || i_word.repeat_forever)
                 && !r_used[id_idx];
    assign unreg_ok = id_ok && r_used[id_idx];

    assign free_now  = !r_used[r_idx];
    assign armed_now = r_used[r_idx] && r_armed[r_idx];
    assign elapsed   = r_item.now_ms - r_rd_base;
    assign fire      = armed_now && (elapsed >= r_rd_period);
    assign loops_dec = r_rd_loops - 16'd1;
    assign freed     = !r_forever[r_idx] && (loops_dec == 16'h0000);

    always_comb begin
        fire_word            = '0;
        fire_word.result_id  = rid;
        fire_word.fired      = 1'b1;
        fire_word.slot_freed = freed;
    end

    assign o_stat.need_search = (i_word.operation == OP_RESERVE)
                             || ((i_word.operation == OP_RUN_ONCE) && period_ok_in);
    assign o_stat.is_scan    = (i_word.operation == OP_SCAN);
    assign o_stat.free_hit   = free_now;
    assign o_stat.idx_last   = (r_idx == LAST_IDX);
    assign o_stat.fires_full = fire && (r_fires == FIRE_W'(MAX_FIRES - 1));

    always_comb begin
        n_used       = r_used;
        n_armed      = r_armed;
        n_forever    = r_forever;
        n_idx        = r_idx;
        n_fires      = r_fires;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        we_period    = 1'b0;
        we_base      = 1'b0;
        we_loops     = 1'b0;
        waddr        = r_idx;
        wd_period    = r_item.period_ms;
        wd_base      = r_item.now_ms;
        wd_loops     = 16'd1;

        if (i_cmd.load) begin
            n_idx        = '0;
            n_fires      = '0;
            n_pend_valid = 1'b0;
        end

        if (i_cmd.single) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.last  = 1'b1;
            n_out.status = 1'b1;
            if (i_word.operation == OP_REGISTER) begin
                if (reg_ok) begin
                    n_out.status      = 1'b0;
                    n_used[id_idx]    = 1'b1;
                    n_armed[id_idx]   = 1'b1;
                    n_forever[id_idx] = i_word.repeat_forever;
                    we_period = 1'b1;
                    we_base   = 1'b1;
                    we_loops  = 1'b1;
                    waddr     = id_idx;
                    wd_period = i_word.period_ms;
                    wd_base   = i_word.now_ms;
                    wd_loops  = i_word.loop_count;
                end
            end else if (i_word.operation == OP_UNREGISTER) begin
                if (unreg_ok) begin
                    n_out.status    = 1'b0;
                    n_used[id_idx]  = 1'b0;
                    n_armed[id_idx] = 1'b0;
                end
            end
        end

        if (i_cmd.search_step) begin
            if (free_now) begin
                n_out_valid     = 1'b1;
                n_out           = '0;
                n_out.result_id = rid;
                n_out.last      = 1'b1;
                n_used[r_idx]   = 1'b1;
                if (r_item.operation == OP_RUN_ONCE && period_ok_item) begin
                    n_armed[r_idx]   = 1'b1;
                    n_forever[r_idx] = 1'b0;
                    we_period = 1'b1;
                    we_base   = 1'b1;
                    we_loops  = 1'b1;
                end else begin
                    n_armed[r_idx] = 1'b0;
                end
            end else begin
                if (r_idx == LAST_IDX) begin
                    n_out_valid  = 1'b1;
                    n_out        = '0;
                    n_out.status = 1'b1;
                    n_out.last   = 1'b1;
                end
                n_idx = r_idx + IDX_W'(1);
            end
        end

        if (i_cmd.scan_eval) begin
            n_idx = r_idx + IDX_W'(1);
            if (fire) begin
                // The earlier fire is known now not to be the final result.
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                end
                n_pend       = fire_word;
                n_pend_valid = 1'b1;
                n_fires      = r_fires + FIRE_W'(1);
                if (freed) begin
                    n_used[r_idx]  = 1'b0;
                    n_armed[r_idx] = 1'b0;
                end else begin
                    we_base = 1'b1;
                    wd_base = r_rd_base + r_rd_period;
                    if (!r_forever[r_idx]) begin
                        we_loops = 1'b1;
                        wd_loops = loops_dec;
                    end
                end
            end
        end

        if (i_cmd.scan_finish) begin
            n_out_valid = 1'b1;
            if (r_pend_valid) begin
                n_out      = r_pend;
                n_out.last = 1'b1;
            end else begin
                n_out      = '0;
                n_out.last = 1'b1;
            end
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_armed      <= '0;
            r_forever    <= '0;
            r_idx        <= '0;
            r_fires      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_used       <= n_used;
            r_armed      <= n_armed;
            r_forever    <= n_forever;
            r_idx        <= n_idx;
            r_fires      <= n_fires;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        if (i_cmd.load) begin
            r_item <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_period) begin
            r_period_mem[waddr] <= wd_period;
        end
        if (we_base) begin
            r_base_mem[waddr] <= wd_base;
        end
        if (we_loops) begin
            r_loops_mem[waddr] <= wd_loops;
        end
        r_rd_period <= r_period_mem[r_idx];
        r_rd_base   <= r_base_mem[r_idx];
        r_rd_loops  <= r_loops_mem[r_idx];
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

// ----- src/periodic_timer_slot_table_unit.sv -----
// ----------------------------------------------------------------------------
// Periodic timer slot table
// A table of timer slots with register, unregister, reserve, run-once and
// scan operations, driven by a command channel and an APB-style port.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge where start is high and busy is
// low. Every result word appears on o_result for exactly one cycle, marked by
// o_result_valid; the receiver cannot stall, so nothing waits for it.
// Register, unregister, unknown codes and a run-once with a short period are
// handled in the accepting cycle: the result shows in the next cycle and busy
// stays low, so a new command may follow at once.
// Reserve and run-once search the slots one per cycle from slot zero; the
// search walks the slot flag registers.
// A scan visits each slot with a memory read, then the elapsed-time compare
// and write-back, and ends with a state that releases the last result. The
// slot memories have a single registered read port.
// Fired slots are held back in a pending register so that the final one carries last.
// Reset clears every slot's used, armed and forever flags and sets the
// minimum interval to ten; period, base and loop memories need no clearing.
// The minimum interval is written at byte address 0 and reads back there.
// ----------------------------------------------------------------------------
module periodic_timer_slot_table_unit
    import ptst_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_word    i_cmd,
    output logic        o_result_valid,
    output t_out_word   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [15:0] r_min_interval;
    t_dp_cmd     dp_cmd;
    t_dp_stat    dp_stat;
    logic        cfg_write;

    // Register 0 occupies the lower word; the upper word holds nothing.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? 32'h0000_0000 : {16'h0000, r_min_interval};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= MIN_INTERVAL_RESET;
        end else if (cfg_write) begin
            r_min_interval <= pwdata[15:0];
        end
    end

    ptst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_cmd   (dp_cmd)
    );

    ptst_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word         (i_cmd),
        .i_min_interval (r_min_interval),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_valid        (o_result_valid),
        .o_word         (o_result)
    );

endmodule

// ----- src/ptst_checker.sv -----
// ----------------------------------------------------------------------------
// Timer slot table checker
// Port-level properties of the slot table, attached to the top level.
// ----------------------------------------------------------------------------
module ptst_checker
    import ptst_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_word  i_cmd,
    input logic      o_result_valid,
    input t_out_word o_result
);

    // Commands finished in the accepting cycle answer with one final word.
    // Codes above the scan code are undefined and are answered at once as well.
    a_single_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.operation == OP_REGISTER
            || i_cmd.operation == OP_UNREGISTER || i_cmd.operation > OP_SCAN))
        |=> (o_result_valid && o_result.last))
        else $error("single-cycle command gave no final result");

    // Leaving a search or a scan always releases the final word.
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_result_valid && o_result.last))
        else $error("busy fell without a final result");

    // Only a fired slot can report being freed.
    a_freed_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.fired) |-> !o_result.slot_freed)
        else $error("slot freed without firing");

    // A rejected word carries no slot and no fire.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status)
        |-> (o_result.result_id == 4'd0 && !o_result.fired))
        else $error("rejected result carries slot data");

endmodule

bind periodic_timer_slot_table_unit ptst_checker u_ptst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
